>>> rtl/random_blink_lid_timer_assert.svh
// Assertion macros shared by the lid timer RTL.
`ifndef RANDOM_BLINK_LID_TIMER_ASSERT_SVH
`define RANDOM_BLINK_LID_TIMER_ASSERT_SVH

// Plain property, sampled on clk, off while in reset.
`define RBLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define RBLT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RBLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rblt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rblt_pkg;

  typedef enum logic [1:0] {
    PH_OPEN    = 2'd0,
    PH_CLOSING = 2'd1,
    PH_OPENING = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_CSTART,
    S_CWAIT,
    S_LCG,
    S_MSTART,
    S_MWAIT,
    S_DONE
  } state_t;

  // config register indexes
  localparam logic [2:0] CFG_INTERVAL_MIN = 3'd0;
  localparam logic [2:0] CFG_INTERVAL_MAX = 3'd1;
  localparam logic [2:0] CFG_CLOSING      = 3'd2;
  localparam logic [2:0] CFG_OPENING      = 3'd3;
  localparam logic [2:0] CFG_SEED         = 3'd4;

  localparam logic [15:0] RST_INTERVAL_MIN = 16'd3000;
  localparam logic [15:0] RST_INTERVAL_MAX = 16'd6000;
  localparam logic [15:0] RST_CLOSING      = 16'd60;
  localparam logic [15:0] RST_OPENING      = 16'd90;
  localparam logic [31:0] RST_SEED         = 32'd1;

  localparam logic [31:0] LCG_MUL        = 32'd1664525;
  localparam logic [31:0] LCG_ADD        = 32'd1013904223;
  localparam logic [7:0]  CLOSED_LID     = 8'd255;
  localparam logic [15:0] SHOW_CLOSED_MS = 16'd20;

  // shared divider: 24-bit dividend (phase_time * 255 or LCG high half), 17-bit divisor (phase duration or span + 1)
  localparam int DIVIDEND_W = 24;
  localparam int DIVISOR_W  = 17;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/rblt_div.sv
`timescale 1ns / 1ps
`default_nettype none
`include "random_blink_lid_timer_assert.svh"

// Restoring divider, one quotient bit per cycle.
module rblt_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rblt_pkg::div_req_t req,
  output rblt_pkg::div_rsp_t      rsp
);

  localparam int DW = rblt_pkg::DIVIDEND_W;
  localparam int VW = rblt_pkg::DIVISOR_W;
  localparam int CW = rblt_pkg::DIV_CNT_W;
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;

  logic [VW:0]   shifted;
  logic [VW+1:0] diff;
  logic          fits;

  always_comb begin
    shifted  = {rem_r, quo_r[DW-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs_r};
    fits     = !diff[VW+1];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[VW-1:0] : shifted[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  `RBLT_ASSERT_IMPL(a_start_idle, req.start, !busy_r, "divider started while busy")
  `RBLT_ASSERT_NEXT(a_start_busy, req.start, busy_r, "divider did not go busy")
  `RBLT_ASSERT_IMPL(a_done_end, done_r, !busy_r && $past(busy_r), "done without a run")

endmodule

`default_nettype wire

>>> rtl/random_blink_lid_timer.sv
`timescale 1ns / 1ps
`default_nettype none
`include "random_blink_lid_timer_assert.svh"

// Random blink lid timer.
// Input channel (in_valid / in_stall / in_elapsed_ms): one transaction per tick,
// carrying the milliseconds since the previous tick. Result channel (out_valid /
// out_stall / out_*): exactly one transaction per tick with lid closure, change flag,
// phase and blink count. Config port (cfg_we / cfg_index / cfg_wdata): write-only,
// taken on any cycle with cfg_we high; write only while the block is idle.
// A small sequencer walks the phases one step per cycle when it is not running the
// LCG or waiting on the divider. Each lid update in closing or opening runs the
// shared divider; each completed blink runs the LCG and the same divider for the
// modulo. The next tick is taken once the current one is finished and handed to
// the output register.
// Reset (rst_n low, synchronous) loads the default config, open phase, time to
// blink 3000 ms, seed 1, and empties the output register.
// A stalled result holds in the output register; a new tick is still taken, but
// its result waits for the register to free up before the block goes idle again.
module random_blink_lid_timer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_elapsed_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_lid_closure,
  output logic             out_closure_changed,
  output logic [1:0]       out_blink_phase,
  output logic [31:0]      out_blinks_done,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int DW = rblt_pkg::DIVIDEND_W;
  localparam int VW = rblt_pkg::DIVISOR_W;

  // config registers
  logic [15:0] min_r, max_r, closing_r, opening_r;

  // block state
  rblt_pkg::state_t state_r, state_nxt;
  rblt_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] pt_r, pt_nxt;          // time spent in closing/opening
  logic [15:0] ttb_r, ttb_nxt;        // open time left
  logic [7:0]  closure_r, closure_nxt;
  logic [31:0] lcg_r, lcg_nxt;
  logic [31:0] blinks_r, blinks_nxt;
  logic [15:0] rem_r, rem_nxt;        // tick time not yet spent
  logic [7:0]  before_r, before_nxt;  // closure at accept

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_closure_r;
  logic        out_changed_r;
  logic [1:0]  out_phase_r;
  logic [31:0] out_blinks_r;
  logic        out_load;

  rblt_pkg::div_req_t div_req;
  rblt_pkg::div_rsp_t div_rsp;

  // datapath terms
  logic [15:0]   dur_close, dur_open, dur, left, span;
  logic [16:0]   open_diff, phase_diff;
  logic [VW-1:0] mod_divisor;
  logic [DW-1:0] scaled_pt;
  logic [31:0]   lcg_step;
  logic [7:0]    quo8;
  logic          in_acc;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    dur_close   = (closing_r == 16'd0) ? 16'd1 : closing_r;
    dur_open    = (opening_r == 16'd0) ? 16'd1 : opening_r;
    dur         = (phase_r == rblt_pkg::PH_CLOSING) ? dur_close : dur_open;
    left        = (dur > pt_r) ? dur - pt_r : 16'd0;
    open_diff   = {1'b0, rem_r} - {1'b0, ttb_r};
    phase_diff  = {1'b0, rem_r} - {1'b0, left};
    span        = (max_r >= min_r) ? max_r - min_r : 16'd0;
    mod_divisor = {1'b0, span} + 17'd1;
    scaled_pt   = {pt_r, 8'd0} - {8'd0, pt_r};  // phase_time * 255
    lcg_step    = lcg_r * rblt_pkg::LCG_MUL + rblt_pkg::LCG_ADD;
    quo8        = div_rsp.quotient[7:0];
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    pt_nxt      = pt_r;
    ttb_nxt     = ttb_r;
    closure_nxt = closure_r;
    lcg_nxt     = lcg_r;
    blinks_nxt  = blinks_r;
    rem_nxt     = rem_r;
    before_nxt  = before_r;
    out_load    = 1'b0;
    in_stall    = (state_r != rblt_pkg::S_IDLE);

    div_req.start    = 1'b0;
    div_req.dividend = scaled_pt;
    div_req.divisor  = {1'b0, dur};

    unique case (state_r)
      rblt_pkg::S_IDLE: begin
        if (in_valid) begin
          rem_nxt    = in_elapsed_ms;
          before_nxt = closure_r;
          state_nxt  = rblt_pkg::S_STEP;
        end
      end
      rblt_pkg::S_STEP: begin
        if (rem_r == 16'd0) begin
          state_nxt = rblt_pkg::S_DONE;
        end else begin
          case (phase_r)
            rblt_pkg::PH_OPEN: begin
              if (open_diff[16]) begin
                ttb_nxt   = ttb_r - rem_r;
                state_nxt = rblt_pkg::S_DONE;
              end else begin
                rem_nxt   = open_diff[15:0];
                ttb_nxt   = 16'd0;
                phase_nxt = rblt_pkg::PH_CLOSING;
                pt_nxt    = 16'd0;
              end
            end
            rblt_pkg::PH_CLOSING: begin
              if (phase_diff[16]) begin
                pt_nxt    = pt_r + rem_r;
                state_nxt = rblt_pkg::S_CSTART;
              end else begin
                rem_nxt     = phase_diff[15:0];
                closure_nxt = rblt_pkg::CLOSED_LID;
                phase_nxt   = rblt_pkg::PH_OPENING;
                pt_nxt      = 16'd0;
                // hold the closed lid for this tick when little time is left
                if (phase_diff[15:0] <= rblt_pkg::SHOW_CLOSED_MS) begin
                  state_nxt = rblt_pkg::S_DONE;
                end
              end
            end
            rblt_pkg::PH_OPENING: begin
              if (phase_diff[16]) begin
                pt_nxt    = pt_r + rem_r;
                state_nxt = rblt_pkg::S_CSTART;
              end else begin
                rem_nxt     = phase_diff[15:0];
                closure_nxt = 8'd0;
                phase_nxt   = rblt_pkg::PH_OPEN;
                pt_nxt      = 16'd0;
                blinks_nxt  = blinks_r + 32'd1;
                state_nxt   = rblt_pkg::S_LCG;
              end
            end
            default: state_nxt = rblt_pkg::S_DONE;
          endcase
        end
      end
      rblt_pkg::S_CSTART: begin
        div_req.start = 1'b1;
        state_nxt     = rblt_pkg::S_CWAIT;
      end
      rblt_pkg::S_CWAIT: begin
        if (div_rsp.done) begin
          closure_nxt = (phase_r == rblt_pkg::PH_CLOSING) ? quo8
                                                          : rblt_pkg::CLOSED_LID - quo8;
          state_nxt   = rblt_pkg::S_DONE;
        end
      end
      rblt_pkg::S_LCG: begin
        lcg_nxt   = lcg_step;
        state_nxt = rblt_pkg::S_MSTART;
      end
      rblt_pkg::S_MSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = {8'd0, lcg_r[31:16]};
        div_req.divisor  = mod_divisor;
        state_nxt        = rblt_pkg::S_MWAIT;
      end
      rblt_pkg::S_MWAIT: begin
        if (div_rsp.done) begin
          ttb_nxt   = min_r + div_rsp.remainder[15:0];
          state_nxt = rblt_pkg::S_STEP;
        end
      end
      rblt_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = rblt_pkg::S_IDLE;
        end
      end
      default: state_nxt = rblt_pkg::S_IDLE;
    endcase

    // seed write reloads the generator
    if (cfg_we && cfg_index == rblt_pkg::CFG_SEED) begin
      lcg_nxt = cfg_wdata;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  rblt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rblt_pkg::S_IDLE;
      phase_r     <= rblt_pkg::PH_OPEN;
      pt_r        <= 16'd0;
      ttb_r       <= rblt_pkg::RST_INTERVAL_MIN;
      closure_r   <= 8'd0;
      lcg_r       <= rblt_pkg::RST_SEED;
      blinks_r    <= 32'd0;
      out_valid_r <= 1'b0;
      min_r       <= rblt_pkg::RST_INTERVAL_MIN;
      max_r       <= rblt_pkg::RST_INTERVAL_MAX;
      closing_r   <= rblt_pkg::RST_CLOSING;
      opening_r   <= rblt_pkg::RST_OPENING;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pt_r        <= pt_nxt;
      ttb_r       <= ttb_nxt;
      closure_r   <= closure_nxt;
      lcg_r       <= lcg_nxt;
      blinks_r    <= blinks_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rblt_pkg::CFG_INTERVAL_MIN: min_r     <= cfg_wdata[15:0];
          rblt_pkg::CFG_INTERVAL_MAX: max_r     <= cfg_wdata[15:0];
          rblt_pkg::CFG_CLOSING:      closing_r <= cfg_wdata[15:0];
          rblt_pkg::CFG_OPENING:      opening_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    before_r <= before_nxt;
    if (out_load) begin
      out_closure_r <= closure_r;
      out_changed_r <= (closure_r != before_r);
      out_phase_r   <= phase_r;
      out_blinks_r  <= blinks_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_lid_closure     = out_closure_r;
  assign out_closure_changed = out_changed_r;
  assign out_blink_phase     = out_phase_r;
  assign out_blinks_done     = out_blinks_r;

  `RBLT_ASSERT_NEXT(a_accept_step, in_acc, state_r == rblt_pkg::S_STEP, "tick not stepped")
  `RBLT_ASSERT_IMPL(a_open_lid, state_r == rblt_pkg::S_IDLE && phase_r == rblt_pkg::PH_OPEN,
                    closure_r == 8'd0, "lid not open in open phase")
  `RBLT_ASSERT_IMPL(a_cwait_phase, state_r == rblt_pkg::S_CWAIT,
                    phase_r != rblt_pkg::PH_OPEN, "lid update in open phase")

endmodule

`default_nettype wire
